/* rtl/core/ilir_pkg.sv */
// Shared types and constants for the indexed list insert/remove unit.
// Holds op codes, status codes, transfer structs and cell control struct.
// No dependencies.
package ilir_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [2:0] {
    OP_PUSH       = 3'd0,
    OP_POP        = 3'd1,
    OP_INSERT_AT  = 3'd2,
    OP_REMOVE_AT  = 3'd3,
    OP_INSERT_MID = 3'd4,
    OP_REMOVE_MID = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [4:0]         position;
    logic signed [31:0] elem_value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [4:0]         count;
  } result_t;

  typedef struct packed {
    logic apply;
    logic insert;
  } cell_ctl_t;

endpackage

/* rtl/core/ilir_cell.sv */
// One storage cell of the list chain; cell 0 holds the tail element.
// Shifts toward or away from the tail under broadcast control.
// Depends on ilir_pkg.
module ilir_cell #(
  parameter int INDEX     = 0,
  parameter int IW        = 5,
  parameter int WORD_BITS = ilir_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  ilir_pkg::cell_ctl_t   ctl,
  input  logic [IW-1:0]         bound,
  input  logic [WORD_BITS-1:0]  word,
  input  logic [WORD_BITS-1:0]  lower,
  input  logic [WORD_BITS-1:0]  upper,
  output logic [WORD_BITS-1:0]  value
);

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic [WORD_BITS-1:0] value_next;

  always_comb begin
    value_next = value;
    if (ctl.apply) begin
      if (ctl.insert) begin
        if (MY_IDX > bound) begin
          value_next = lower;
        end else if (MY_IDX == bound) begin
          value_next = word;
        end
      end else if (MY_IDX >= bound) begin
        value_next = upper;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

/* rtl/core/ilir_ctrl.sv */
// Operation decode, fill count and result register for the list unit.
// Drives the cell chain with a shift boundary and mode.
// Depends on ilir_pkg.
module ilir_ctrl #(
  parameter int DEPTH     = ilir_pkg::DEPTH_DEF,
  parameter int WORD_BITS = ilir_pkg::WORD_BITS_DEF,
  parameter int CW        = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  ilir_pkg::cmd_t       cmd,
  input  logic [WORD_BITS-1:0] head,
  output ilir_pkg::cell_ctl_t  ctl,
  output logic [CW-1:0]        bound,
  output logic [WORD_BITS-1:0] word,
  output logic                 done,
  output ilir_pkg::result_t    result
);

  localparam int EW = ((CW > 5) ? CW : 5) + 1;

  logic [CW-1:0]       cnt, cnt_next;
  logic [EW-1:0]       cnt_e, pos_e, half_e, at;
  logic                do_ins, do_rem, is_pop;
  ilir_pkg::status_t   status;
  ilir_pkg::result_t   result_next;

  assign cnt_e  = EW'(cnt);
  assign pos_e  = EW'(cmd.position);
  assign half_e = EW'(cnt >> 1);
  assign word   = WORD_BITS'($unsigned(cmd.elem_value));

  always_comb begin
    do_ins = 1'b0;
    do_rem = 1'b0;
    is_pop = 1'b0;
    at     = '0;
    case (ilir_pkg::op_t'(cmd.op))
      ilir_pkg::OP_PUSH: begin
        do_ins = 1'b1;
        at     = cnt_e;
      end
      ilir_pkg::OP_POP: begin
        do_rem = 1'b1;
        is_pop = 1'b1;
        at     = cnt_e - EW'(1);
      end
      ilir_pkg::OP_INSERT_AT: begin
        do_ins = 1'b1;
        at     = pos_e;
      end
      ilir_pkg::OP_REMOVE_AT: begin
        do_rem = 1'b1;
        at     = pos_e;
      end
      ilir_pkg::OP_INSERT_MID: begin
        do_ins = 1'b1;
        at     = half_e;
      end
      ilir_pkg::OP_REMOVE_MID: begin
        do_rem = 1'b1;
        at     = half_e;
      end
      default: begin
        do_ins = 1'b0;
      end
    endcase
  end

  always_comb begin
    status     = ilir_pkg::ST_OK;
    ctl.apply  = 1'b0;
    ctl.insert = do_ins;
    bound      = '0;
    cnt_next   = cnt;
    if (do_ins) begin
      if (at > cnt_e) begin
        status = ilir_pkg::ST_RANGE;
      end else if (cnt_e >= EW'(DEPTH)) begin
        status = ilir_pkg::ST_FULL;
      end else begin
        ctl.apply = accept;
        bound     = CW'(cnt_e - at);
        cnt_next  = CW'(cnt + 1'b1);
      end
    end else if (do_rem) begin
      if (cnt == '0) begin
        status = ilir_pkg::ST_EMPTY;
      end else if (at >= cnt_e) begin
        status = ilir_pkg::ST_RANGE;
      end else begin
        ctl.apply = accept;
        bound     = CW'(cnt_e - EW'(1) - at);
        cnt_next  = CW'(cnt - 1'b1);
      end
    end
  end

  always_comb begin
    result_next.popped_value = '0;
    if (is_pop && status == ilir_pkg::ST_OK) begin
      result_next.popped_value = 32'(head);
    end
    result_next.status = status;
    result_next.count  = 5'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        cnt <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

`ifndef ASSERT_OFF
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done) else $error("transfer not answered next cycle");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done) else $error("result without transfer");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH)) else $error("fill count beyond depth");
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ilir_pkg::ST_FULL) |-> cnt == CW'(DEPTH))
    else $error("full reported while not full");
  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ilir_pkg::ST_EMPTY) |-> cnt == '0)
    else $error("empty reported while not empty");
`endif

endmodule

/* rtl/core/indexed_list_insert_remove_unit.sv */
// Indexed list insert/remove unit: ordered list in a chain of shift cells.
// The result strobe comes in the cycle after the transfer; all shifting of the
// cell chain happens at the same clock edge that registers the result.
// Throughput: one operation per cycle; busy stays low, as the cell chain and
// fill count are updated together with the result register.
// Reset (rst, synchronous): fill count cleared, no result pending.
module indexed_list_insert_remove_unit #(
  parameter int DEPTH     = ilir_pkg::DEPTH_DEF,
  parameter int WORD_BITS = ilir_pkg::WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ilir_pkg::cmd_t    cmd,
  output logic              done,
  output ilir_pkg::result_t result
);

  localparam int CW = $clog2(DEPTH + 1);

  ilir_pkg::cell_ctl_t  ctl;
  logic [CW-1:0]        bound;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] cell_value [DEPTH];
  logic                 accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  ilir_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .CW        (CW)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .head   (cell_value[0]),
    .ctl    (ctl),
    .bound  (bound),
    .word   (word),
    .done   (done),
    .result (result)
  );

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic [WORD_BITS-1:0] lower, upper;
    if (j == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_value[j-1];
    end
    if (j == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_value[j+1];
    end
    ilir_cell #(
      .INDEX     (j),
      .IW        (CW),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .bound (bound),
      .word  (word),
      .lower (lower),
      .upper (upper),
      .value (cell_value[j])
    );
  end

endmodule

/* bench/tb_top.sv */
// Testbench for indexed_list_insert_remove_unit: directed and random list operations.
// Predicts every result from a local list model and checks each done strobe in order.
// Depends on ilir_pkg and the unit's RTL.
module tb_top;

  localparam int DEPTH = ilir_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1750;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  ilir_pkg::cmd_t    cmd = '0;
  logic              done;
  ilir_pkg::result_t result;

  ilir_pkg::cmd_t    pending_cmds[$];
  ilir_pkg::result_t expected_results[$];
  ilir_pkg::result_t want;

  logic signed [31:0] list_words[DEPTH];
  int list_fill;
  int error_count;
  int items_sent;
  int total_items;
  int idle_pct;
  int stall_cycles;

  indexed_list_insert_remove_unit i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic ilir_pkg::status_t insert_word(int at, logic signed [31:0] w);
    if (at > list_fill) return ilir_pkg::ST_RANGE;
    if (list_fill >= DEPTH) return ilir_pkg::ST_FULL;
    for (int i = list_fill; i > at; i--) list_words[i] = list_words[i - 1];
    list_words[at] = w;
    list_fill++;
    return ilir_pkg::ST_OK;
  endfunction

  function automatic ilir_pkg::status_t remove_word(int at);
    if (list_fill == 0) return ilir_pkg::ST_EMPTY;
    if (at >= list_fill) return ilir_pkg::ST_RANGE;
    for (int i = at; i + 1 < list_fill; i++) list_words[i] = list_words[i + 1];
    list_fill--;
    return ilir_pkg::ST_OK;
  endfunction

  function automatic ilir_pkg::result_t apply_list_op(ilir_pkg::cmd_t c);
    ilir_pkg::result_t r;
    r = '0;
    r.status = ilir_pkg::ST_OK;
    case (c.op)
      ilir_pkg::OP_PUSH:       r.status = insert_word(list_fill, c.elem_value);
      ilir_pkg::OP_POP: begin
        if (list_fill == 0) begin
          r.status = ilir_pkg::ST_EMPTY;
        end else begin
          list_fill--;
          r.popped_value = list_words[list_fill];
        end
      end
      ilir_pkg::OP_INSERT_AT:  r.status = insert_word(int'(c.position), c.elem_value);
      ilir_pkg::OP_REMOVE_AT:  r.status = remove_word(int'(c.position));
      ilir_pkg::OP_INSERT_MID: r.status = insert_word(list_fill / 2, c.elem_value);
      ilir_pkg::OP_REMOVE_MID: r.status = remove_word(list_fill / 2);
      default: ;
    endcase
    r.count = 5'(list_fill);
    return r;
  endfunction

  task automatic add_item(input logic [2:0] op, input logic [4:0] pos,
                          input logic signed [31:0] val);
    ilir_pkg::cmd_t c;
    c.op = op;
    c.position = pos;
    c.elem_value = val;
    pending_cmds.push_back(c);
    void'(apply_list_op(c));
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 19))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh00000000;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic build_stimulus();
    logic [2:0] op;
    logic [4:0] pos;
    int roll;
    int grow;
    list_fill = 0;
    // empty list
    add_item(ilir_pkg::OP_POP, 5'd0, 32'sd0);
    add_item(ilir_pkg::OP_REMOVE_AT, 5'd0, 32'sd0);
    add_item(ilir_pkg::OP_REMOVE_MID, 5'd0, 32'sd0);
    add_item(ilir_pkg::OP_INSERT_AT, 5'd1, 32'sd5);
    // fill to capacity
    add_item(ilir_pkg::OP_PUSH, 5'd31, 32'sh7fffffff);
    add_item(ilir_pkg::OP_PUSH, 5'd0, 32'sh80000000);
    add_item(ilir_pkg::OP_INSERT_AT, 5'd0, -32'sd1);
    add_item(ilir_pkg::OP_INSERT_AT, 5'd3, 32'sd0);
    add_item(ilir_pkg::OP_INSERT_MID, 5'd16, 32'sh55555555);
    for (int i = 0; i < 11; i++) begin
      case (i % 3)
        0: add_item(ilir_pkg::OP_INSERT_AT, 5'(i / 2), $urandom);
        1: add_item(ilir_pkg::OP_INSERT_MID, 5'd31, $urandom);
        default: add_item(ilir_pkg::OP_PUSH, 5'(i), $urandom);
      endcase
    end
    // full list
    add_item(ilir_pkg::OP_PUSH, 5'd0, 32'sd1);
    add_item(ilir_pkg::OP_INSERT_AT, 5'd17, 32'sd2);
    add_item(ilir_pkg::OP_INSERT_AT, 5'd5, 32'sd3);
    add_item(ilir_pkg::OP_INSERT_MID, 5'd0, 32'sd4);
    add_item(ilir_pkg::OP_REMOVE_AT, 5'd16, 32'sd0);
    add_item(ilir_pkg::OP_REMOVE_AT, 5'd31, 32'sd0);
    add_item(OP_SPARE_A, 5'd3, 32'sd9);
    add_item(OP_SPARE_B, 5'd31, -32'sd9);
    add_item(ilir_pkg::OP_REMOVE_MID, 5'd0, 32'sd0);
    add_item(ilir_pkg::OP_REMOVE_AT, 5'd0, 32'sd0);
    add_item(ilir_pkg::OP_POP, 5'd0, 32'sd0);

    grow = 1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) grow = $urandom_range(0, 1);
      roll = $urandom_range(0, 99);
      pos = 5'($urandom_range(0, 31));
      if (roll < 4) begin
        op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
      end else if (grow ? roll < 66 : roll < 34) begin
        case ($urandom_range(0, 2))
          0: op = ilir_pkg::OP_PUSH;
          1: op = ilir_pkg::OP_INSERT_AT;
          default: op = ilir_pkg::OP_INSERT_MID;
        endcase
        if (op == ilir_pkg::OP_INSERT_AT && $urandom_range(0, 99) >= 12)
          pos = 5'($urandom_range(0, list_fill));
      end else begin
        case ($urandom_range(0, 2))
          0: op = ilir_pkg::OP_POP;
          1: op = ilir_pkg::OP_REMOVE_AT;
          default: op = ilir_pkg::OP_REMOVE_MID;
        endcase
        if (op == ilir_pkg::OP_REMOVE_AT && list_fill > 0 && $urandom_range(0, 99) >= 12)
          pos = 5'($urandom_range(0, list_fill - 1));
      end
      add_item(op, pos, pick_word());
    end
    total_items = pending_cmds.size();
    list_fill = 0;
  endtask

  // driver: hold the item while busy, advance after each transfer
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) items_sent++;
      if (items_sent < total_items / 3) idle_pct = 21;
      else if (items_sent < 2 * total_items / 3) idle_pct = 63;
      else idle_pct = 0;
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        cmd <= pending_cmds.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on each transfer, check each result strobe
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (start && !busy) expected_results.push_back(apply_list_op(cmd));
      if (done) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result with no pending expectation");
        end else begin
          want = expected_results.pop_front();
          if (result.popped_value !== want.popped_value)
            flag_mismatch($sformatf("popped_value got %0d want %0d",
                                    result.popped_value, want.popped_value));
          if (result.status !== want.status)
            flag_mismatch($sformatf("status got %0d want %0d", result.status, want.status));
          if (result.count !== want.count)
            flag_mismatch($sformatf("count got %0d want %0d", result.count, want.count));
        end
      end
      if ((start && !busy) || done) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    error_count = 0;
    items_sent = 0;
    build_stimulus();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pending_cmds.size() != 0 || start) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_results.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
